// ===== hw/rtl/mmaf_pkg.sv =====
// Shared widths, register indexes, reset values and types of the moving-average force block.
`default_nettype none

package mmaf_pkg;

   localparam int CHAN_W     = 3;
   localparam int SAMPLE_W   = 12;
   localparam int SLOPE_W    = 24;
   localparam int FORCE_W    = 35;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 35;

   localparam logic [CSR_IDX_W-1:0] REG_SLOPE_THUMB    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE_INDEX    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE_MIDDLE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE_RING     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE_LITTLE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OVERLOAD_LEVEL = 3'd5;

   localparam logic [SLOPE_W-1:0] SLOPE_RESET = 24'd65536;
   localparam logic [FORCE_W-1:0] LEVEL_RESET = 35'd655360;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mmaf_if.sv =====
// Request and response channel interfaces of the moving-average force block.
`default_nettype none

interface mmaf_req_if;
   import mmaf_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0]   channel;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mmaf_rsp_if;
   import mmaf_pkg::*;
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   out_channel;
   logic [SAMPLE_W-1:0] filtered;
   logic [FORCE_W-1:0]  force_res;
   logic                overload;

   modport source (output valid, output out_channel, output filtered, output force_res,
                   output overload, input ready);
   modport sink   (input valid, input out_channel, input filtered, input force_res,
                   input overload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mmaf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mmaf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 40
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mmaf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module mmaf_div #(
   parameter int DVD_W = 16,
   parameter int DVS_W = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DVD_W-1:0]     dividend,
   input  wire logic [DVS_W-1:0]     divisor,
   output mmaf_pkg::div_sts_type     sts,
   output logic      [DVD_W-1:0]     quotient
);

   import mmaf_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         rem_ff <= fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_moving_average_force.sv =====
// Per-channel moving-average filter with signed slope scaling and overload flag.
`default_nettype none

// Each request carries a 12-bit sample and its channel. The block keeps, per channel, a ring
// of the last WINDOW samples in a RAM, a write pointer, a fill count and a running sum, and
// answers with the truncated mean, the force max(0, slope * mean) in Q.16 and an overload flag
// (force at or above overload_level). A channel at or above CHANNELS gives zeros and changes
// nothing. A request passes through the ring read, the state update, one step per quotient
// bit in the shared restoring divider, the multiply and the result load; an out-of-range
// request goes straight to the result load. The result register lets a new request in while
// the previous response waits. Slope and level registers must be written through the csr_
// port only while the block is idle; the block itself does not enforce this.
module multichannel_moving_average_force #(
   parameter int CHANNELS = 5,
   parameter int WINDOW   = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   mmaf_req_if.sink                           req_chan,
   mmaf_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [mmaf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mmaf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import mmaf_pkg::*;

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W   = $clog2(WINDOW + 1);
   localparam int SUM_W    = SAMPLE_W + FILL_W;
   localparam int DEPTH    = CHANNELS * WINDOW;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W   = SLOPE_W + SAMPLE_W + 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FETCH  = 3'd1;
   localparam logic [2:0] S_UPDATE = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_MUL    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0]                state_ff;
   logic [2:0]                state_in;
   logic [CHAN_W-1:0]         ch_ff;
   logic [SAMPLE_W-1:0]       smp_ff;
   logic                      bad_ff;
   logic [SAMPLE_W-1:0]       mean_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [SLOPE_W-1:0] slope_ff [CHANNELS];
   logic [FORCE_W-1:0]        level_ff;
   logic [PTR_W-1:0]          wp_ff    [CHANNELS];
   logic [FILL_W-1:0]         fill_ff  [CHANNELS];
   logic [SUM_W-1:0]          sum_ff   [CHANNELS];

   logic                      rsp_valid_ff;
   logic [CHAN_W-1:0]         rsp_ch_ff;
   logic [SAMPLE_W-1:0]       rsp_filt_ff;
   logic [FORCE_W-1:0]        rsp_force_ff;
   logic                      rsp_ovl_ff;

   logic [CH_IDX_W-1:0]       ch_idx;
   logic [ADDR_W-1:0]         slot_addr;
   logic [SAMPLE_W-1:0]       old_smp;
   logic                      full;
   logic [SUM_W-1:0]          sum_in;
   logic [FILL_W-1:0]         fill_in;
   logic [PTR_W-1:0]          wp_in;
   logic [FORCE_W-1:0]        force_val;
   logic                      req_fire;
   logic                      req_bad;
   logic                      out_free;
   logic                      div_start;
   div_sts_type               div_sts;
   logic [SUM_W-1:0]          quotient;

   assign ch_idx    = ch_ff[CH_IDX_W-1:0];
   assign slot_addr = ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(wp_ff[ch_idx]);
   assign full      = fill_ff[ch_idx] == FILL_W'(WINDOW);
   assign sum_in    = sum_ff[ch_idx] - (full ? SUM_W'(old_smp) : SUM_W'(0)) + SUM_W'(smp_ff);
   assign fill_in   = full ? fill_ff[ch_idx] : fill_ff[ch_idx] + 1'b1;
   assign wp_in     = (wp_ff[ch_idx] == PTR_W'(WINDOW - 1)) ? '0 : wp_ff[ch_idx] + 1'b1;
   assign force_val = (bad_ff || prod_ff[PROD_W-1]) ? '0 : prod_ff[FORCE_W-1:0];

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign req_bad   = req_chan.channel >= CHAN_W'(CHANNELS);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign div_start = state_ff == S_UPDATE;

   assign req_chan.ready = state_ff == S_IDLE;

   mmaf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == S_UPDATE),
      .wr_addr (slot_addr),
      .wr_data (smp_ff),
      .rd_en   (state_ff == S_FETCH),
      .rd_addr (slot_addr),
      .rd_data (old_smp)
   );

   mmaf_div #(
      .DVD_W (SUM_W),
      .DVS_W (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (fill_in),
      .sts      (div_sts),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = req_bad ? S_OUT : S_FETCH;
            end
         end
         S_FETCH:  state_in = S_UPDATE;
         S_UPDATE: state_in = S_DIV;
         S_DIV: begin
            if (div_sts.done) begin
               state_in = S_MUL;
            end
         end
         S_MUL:    state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // per-channel filter state and slopes, and the shared overload level
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            slope_ff[c] <= SLOPE_RESET;
            wp_ff[c]    <= '0;
            fill_ff[c]  <= '0;
            sum_ff[c]   <= '0;
         end
         level_ff <= LEVEL_RESET;
      end else begin
         if (csr_we) begin
            if (csr_index <= REG_SLOPE_LITTLE && csr_index < CSR_IDX_W'(CHANNELS)) begin
               slope_ff[csr_index[CH_IDX_W-1:0]] <= csr_wdata[SLOPE_W-1:0];
            end else if (csr_index == REG_OVERLOAD_LEVEL) begin
               level_ff <= csr_wdata[FORCE_W-1:0];
            end
         end
         if (state_ff == S_UPDATE) begin
            sum_ff[ch_idx]  <= sum_in;
            fill_ff[ch_idx] <= fill_in;
            wp_ff[ch_idx]   <= wp_in;
         end
      end
   end

   // request datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff  <= req_chan.channel;
         smp_ff <= req_chan.sample;
         bad_ff <= req_bad;
         if (req_bad) begin
            mean_ff <= '0;
            prod_ff <= '0;
         end
      end
      if (state_ff == S_DIV && div_sts.done) begin
         mean_ff <= quotient[SAMPLE_W-1:0];
      end
      if (state_ff == S_MUL) begin
         prod_ff <= slope_ff[ch_idx] * $signed({1'b0, mean_ff});
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_ch_ff    <= ch_ff;
         rsp_filt_ff  <= mean_ff;
         rsp_force_ff <= force_val;
         rsp_ovl_ff   <= !bad_ff && (force_val >= level_ff);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_channel = rsp_ch_ff;
   assign rsp_chan.filtered    = rsp_filt_ff;
   assign rsp_chan.force_res   = rsp_force_ff;
   assign rsp_chan.overload    = rsp_ovl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mmaf_checker.sv =====
// Port-level checks of the moving-average force block and their bind to the top level.
`default_nettype none

module mmaf_checker #(
   parameter int CHANNELS = 5
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [mmaf_pkg::CHAN_W-1:0]   out_channel,
   input wire logic [mmaf_pkg::SAMPLE_W-1:0] filtered,
   input wire logic [mmaf_pkg::FORCE_W-1:0]  force_res,
   input wire logic                          overload
);

   import mmaf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_bad_channel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_channel >= CHAN_W'(CHANNELS)
         |-> filtered == '0 && force_res == '0 && !overload)
      else $error("rejected channel gave a nonzero result");

   a_force_needs_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && force_res != '0 |-> filtered != '0)
      else $error("nonzero force from zero mean");

endmodule

bind multichannel_moving_average_force mmaf_checker #(
   .CHANNELS (CHANNELS)
) u_mmaf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_channel (rsp_chan.out_channel),
   .filtered    (rsp_chan.filtered),
   .force_res   (rsp_chan.force_res),
   .overload    (rsp_chan.overload)
);

`default_nettype wire

// ===== sim/mmaf_force_check.sv =====
`timescale 1ns / 1ps
// Response checker for the moving-average force block: predicts each response and compares it.
module mmaf_force_check #(
   parameter int CHANNELS = 5,
   parameter int WINDOW   = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   mmaf_req_if                              req_mon,
   mmaf_rsp_if                              rsp_mon,
   input  logic                             csr_we,
   input  logic [mmaf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mmaf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatch_count,
   output int                               outstanding
);
   import mmaf_pkg::*;

   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      logic [CHAN_W-1:0]   out_channel;
      logic [SAMPLE_W-1:0] filtered;
      logic [FORCE_W-1:0]  force_res;
      logic                overload;
   } force_result_type;

   logic [SAMPLE_W-1:0]       sample_hist [CHANNELS][WINDOW];
   int                        next_slot [CHANNELS];
   int                        fill_level [CHANNELS];
   int                        window_sum [CHANNELS];
   logic signed [SLOPE_W-1:0] slope_q16 [CHANNELS];
   logic [FORCE_W-1:0]        overload_limit;
   force_result_type          pending_forces [$];

   function automatic force_result_type filter_sample(logic [CHAN_W-1:0] chan,
                                                      logic [SAMPLE_W-1:0] smp);
      force_result_type                res;
      int                              c;
      int                              mean;
      logic signed [SLOPE_W+SAMPLE_W:0] product;
      res = '0;
      res.out_channel = chan;
      c = int'(chan);
      if (c >= CHANNELS) return res;
      if (fill_level[c] >= WINDOW) window_sum[c] -= int'(sample_hist[c][next_slot[c]]);
      else fill_level[c]++;
      sample_hist[c][next_slot[c]] = smp;
      window_sum[c] += int'(smp);
      next_slot[c] = (next_slot[c] + 1) % WINDOW;
      mean = window_sum[c] / fill_level[c];
      res.filtered = mean[SAMPLE_W-1:0];
      product = slope_q16[c] * $signed({1'b0, res.filtered});
      res.force_res = (product < 0) ? '0 : product[FORCE_W-1:0];
      res.overload = (res.force_res >= overload_limit);
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got_v, logic [63:0] want_v,
                                  logic [CHAN_W-1:0] chan);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t: mismatch in %s on channel %0d: got %0d, expected %0d",
                  $time, field, chan, got_v, want_v);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      force_result_type got;
      force_result_type want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            for (int s = 0; s < WINDOW; s++) sample_hist[c][s] = '0;
            next_slot[c]  = 0;
            fill_level[c] = 0;
            window_sum[c] = 0;
            slope_q16[c]  = SLOPE_RESET;
         end
         overload_limit = LEVEL_RESET;
         pending_forces.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_OVERLOAD_LEVEL)
               overload_limit = csr_wdata[FORCE_W-1:0];
            else if (csr_index <= REG_SLOPE_LITTLE && int'(csr_index) < CHANNELS)
               slope_q16[csr_index] = csr_wdata[SLOPE_W-1:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.out_channel = rsp_mon.out_channel;
            got.filtered    = rsp_mon.filtered;
            got.force_res   = rsp_mon.force_res;
            got.overload    = rsp_mon.overload;
            if (pending_forces.size() == 0) begin
               report_mismatch("response with no request", got.force_res, 0, got.out_channel);
            end else begin
               want = pending_forces.pop_front();
               if (got.out_channel !== want.out_channel)
                  report_mismatch("out_channel", got.out_channel, want.out_channel,
                                  want.out_channel);
               if (got.filtered !== want.filtered)
                  report_mismatch("filtered", got.filtered, want.filtered, want.out_channel);
               if (got.force_res !== want.force_res)
                  report_mismatch("force_res", got.force_res, want.force_res, want.out_channel);
               if (got.overload !== want.overload)
                  report_mismatch("overload", got.overload, want.overload, want.out_channel);
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_forces.push_back(filter_sample(req_mon.channel, req_mon.sample));
      end
      outstanding = pending_forces.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the moving-average force block: clock, reset, stimulus, pacing and verdict.
module testbench;
   import mmaf_pkg::*;

   localparam int CHANNELS        = 5;
   localparam int WINDOW          = 8;
   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 6;
   localparam int WATCHDOG_CYCLES = 1_000_000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES     = 40;
   localparam int RANDOM_PHASES   = 10;
   localparam int HOLD_PHASE      = 3;
   localparam int STEADY_PHASE    = 5;
   localparam int CHAN_LIMIT      = 1 << CHAN_W;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = REG_OVERLOAD_LEVEL + 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = '1;
   localparam logic [FORCE_W-1:0]   LEVEL_TOP    = 35'd34351345665;
   localparam logic [SLOPE_W-1:0]   SLOPE_MIN    = 24'h800000;
   localparam logic [SLOPE_W-1:0]   SLOPE_MAX    = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX   = '1;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  no_gaps   = 1'b0;
   logic                  hold_rsp  = 1'b0;
   int                    mismatch_count;
   int                    outstanding;
   int                    sent_count      = 0;
   int                    off_range_count = 0;
   int                    setting_count   = 0;
   logic [SLOPE_W-1:0]    slope_plan [CHANNELS];
   logic [FORCE_W-1:0]    level_plan;

   mmaf_req_if req_bus ();
   mmaf_rsp_if rsp_bus ();

   multichannel_moving_average_force #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mmaf_force_check #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) force_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic [CHAN_W-1:0] rand_channel();
      if ($urandom_range(0, 9) == 0) return CHAN_W'($urandom_range(CHANNELS, CHAN_LIMIT - 1));
      return CHAN_W'($urandom_range(0, CHANNELS - 1));
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return SAMPLE_MAX;
         2: return SAMPLE_W'($urandom_range(0, 15));
         3: return SAMPLE_W'($urandom_range(4080, 4095));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [SLOPE_W-1:0] rand_slope();
      case ($urandom_range(0, 7))
         0: return SLOPE_MIN;
         1: return SLOPE_MAX;
         2: return '0;
         3: return SLOPE_W'($urandom_range(32768, 262144));
         4: return -SLOPE_W'($urandom_range(1, 262144));
         default: return SLOPE_W'($urandom);
      endcase
   endfunction

   function automatic logic [FORCE_W-1:0] rand_level();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return LEVEL_TOP;
         2: return '1;
         3: return FORCE_W'($urandom_range(0, 32'h1000_0000));
         default: return {3'($urandom), $urandom};
      endcase
   endfunction

   task automatic send_request(logic [CHAN_W-1:0] chan, logic [SAMPLE_W-1:0] smp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.channel <= chan;
      req_bus.sample  <= smp;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent_count++;
      if (int'(chan) >= CHANNELS) off_range_count++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_settings();
      logic [CSR_DATA_W-SLOPE_W-1:0] upper;
      for (int c = 0; c < CHANNELS; c++) begin
         upper = (CSR_DATA_W - SLOPE_W)'($urandom);
         write_reg(REG_SLOPE_THUMB + CSR_IDX_W'(c), {upper, slope_plan[c]});
      end
      write_reg(REG_OVERLOAD_LEVEL, level_plan);
      setting_count++;
   endtask

   initial begin : rsp_pacing
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            gap = RSP_HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            gap = pick_gap();
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   initial begin : stimulus
      int n_items;
      req_bus.valid   = 1'b0;
      req_bus.channel = '0;
      req_bus.sample  = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill channel 1 past its window, touch every channel and the unused ones
      for (int k = 0; k <= WINDOW; k++) send_request(CHAN_W'(1), SAMPLE_MAX);
      send_request(CHAN_W'(0), '0);
      send_request(CHAN_W'(2), SAMPLE_W'(1));
      send_request(CHAN_W'(3), 12'd2048);
      send_request(CHAN_W'(4), SAMPLE_MAX);
      for (int c = CHANNELS; c < CHAN_LIMIT; c++) send_request(CHAN_W'(c), SAMPLE_MAX);

      // extreme slopes, force equal to the top level, negative clamp
      wait_idle();
      slope_plan = '{SLOPE_MIN, SLOPE_MAX, '0, '1, 24'd1};
      level_plan = LEVEL_TOP;
      load_settings();
      send_request(CHAN_W'(1), SAMPLE_MAX);
      send_request(CHAN_W'(0), SAMPLE_MAX);
      send_request(CHAN_W'(3), SAMPLE_MAX);
      send_request(CHAN_W'(4), SAMPLE_MAX);
      send_request(CHAN_W'(2), SAMPLE_MAX);

      // zero level flags every response
      wait_idle();
      level_plan = '0;
      load_settings();
      send_request(CHAN_W'(0), '0);
      send_request(CHAN_W'(2), '0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         for (int c = 0; c < CHANNELS; c++) slope_plan[c] = rand_slope();
         level_plan = rand_level();
         load_settings();
         if (p == 0) begin
            write_reg(REG_SPARE_LO, '1);
            write_reg(REG_SPARE_HI, '1);
         end
         no_gaps = (p == STEADY_PHASE);
         if (p == HOLD_PHASE) hold_rsp = 1'b1;
         n_items = $urandom_range(38, 48);
         repeat (n_items) send_request(rand_channel(), rand_sample());
      end

      wait_idle();
      no_gaps = 1'b0;
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Sent %0d requests (%0d on unused channels) across %0d slope/level settings,",
               sent_count, off_range_count, setting_count);
      $display("with window wrap, clamping, level extremes, a long stall and a gap-free phase.");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("multichannel_moving_average_force test passed");
      end else begin
         $display("multichannel_moving_average_force test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(WATCHDOG_CYCLES * CLK_PERIOD);
      $display("multichannel_moving_average_force test failed");
      $finish;
   end

endmodule
